// File: rtl/xfr_pkg.sv
// Package for the XOR-checksum frame receiver.
// Holds the result word type, result kinds, framing bytes and ring slot sizing.
// No dependencies.
`default_nettype none

package xfr_pkg;

	localparam int RING_SLOTS = 8;
	localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int SLOT_FIELD_W = 3;

	localparam logic [7:0] HEADER_BYTE = 8'hFF;
	localparam logic [7:0] FOOTER_BYTE = 8'hFF;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_ACCEPTED  = 2'd1,
		KIND_CHK_ERROR = 2'd2,
		KIND_DROPPED   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic [7:0]              frame_id;
		logic [7:0]              frame_len;
		logic [7:0]              data_byte;
		logic [7:0]              byte_index;
		logic [SLOT_FIELD_W-1:0] slot_index;
	} result_t;

	// The reported slot field is the ring slot masked to three bits.
	function automatic logic [SLOT_FIELD_W-1:0] slot_field(input slot_t s);
		logic [SLOT_W+SLOT_FIELD_W-1:0] ext;
		ext = {{SLOT_FIELD_W{1'b0}}, s};
		return ext[SLOT_FIELD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/xfr_parser.sv
// Frame parser: phase register, held header fields, running XOR and ring slot.
// Produces at most one result word per processed byte. Depends on xfr_pkg.
`default_nettype none

module xfr_parser
	import xfr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire logic [7:0] rx_byte,
	output logic         res_valid,
	output result_t      res
);

	typedef enum logic [2:0] {
		PH_WAIT_HEADER = 3'd0,
		PH_ID          = 3'd1,
		PH_LEN         = 3'd2,
		PH_DATA        = 3'd3,
		PH_CHECK       = 3'd4,
		PH_FOOTER      = 3'd5
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] held_id_q, held_id_d;
	logic [7:0] held_len_q, held_len_d;
	logic [7:0] count_q, count_d;
	logic [7:0] xor_q, xor_d;
	slot_t      slot_q, slot_d;
	slot_t      slot_next;
	logic [7:0] count_inc;

	assign slot_next = (slot_q == SLOT_W'(RING_SLOTS - 1)) ? '0 : slot_q + SLOT_W'(1);
	assign count_inc = count_q + 8'd1;

	always_comb begin
		phase_d    = phase_q;
		held_id_d  = held_id_q;
		held_len_d = held_len_q;
		count_d    = count_q;
		xor_d      = xor_q;
		slot_d     = slot_q;
		res_valid  = 1'b0;
		res.kind       = KIND_PAYLOAD;
		res.frame_id   = held_id_q;
		res.frame_len  = held_len_q;
		res.data_byte  = 8'd0;
		res.byte_index = 8'd0;
		res.slot_index = slot_field(slot_q);
		case (phase_q)
			PH_ID: begin
				held_id_d  = rx_byte;
				held_len_d = 8'd0;
				xor_d      = xor_q ^ rx_byte;
				phase_d    = PH_LEN;
			end
			PH_LEN: begin
				held_len_d = rx_byte;
				count_d    = 8'd0;
				xor_d      = xor_q ^ rx_byte;
				phase_d    = PH_DATA;
			end
			PH_DATA: begin
				xor_d = xor_q ^ rx_byte;
				if (held_len_q == 8'd0) begin
					phase_d = PH_CHECK;
				end else begin
					res_valid      = 1'b1;
					res.data_byte  = rx_byte;
					res.byte_index = count_q;
					count_d        = count_inc;
					if (count_inc >= held_len_q || count_inc == 8'd0) begin
						phase_d = PH_CHECK;
					end
				end
			end
			PH_CHECK: begin
				if (rx_byte == xor_q) begin
					phase_d = PH_FOOTER;
				end else begin
					res_valid = 1'b1;
					res.kind  = KIND_CHK_ERROR;
					phase_d   = PH_WAIT_HEADER;
				end
			end
			PH_FOOTER: begin
				phase_d   = PH_WAIT_HEADER;
				xor_d     = 8'd0;
				res_valid = 1'b1;
				if (rx_byte == FOOTER_BYTE) begin
					slot_d         = slot_next;
					res.kind       = KIND_ACCEPTED;
					res.slot_index = slot_field(slot_next);
				end else begin
					res.kind = KIND_DROPPED;
				end
			end
			default: begin
				phase_d = PH_WAIT_HEADER;
				if (rx_byte == HEADER_BYTE) begin
					phase_d = PH_ID;
					xor_d   = 8'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT_HEADER;
			held_id_q  <= 8'd0;
			held_len_q <= 8'd0;
			count_q    <= 8'd0;
			xor_q      <= 8'd0;
			slot_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			held_id_q  <= held_id_d;
			held_len_q <= held_len_d;
			count_q    <= count_d;
			xor_q      <= xor_d;
			slot_q     <= slot_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/xfr_out_buf.sv
// Two-word result register with skid entry, decoupling the parser from output stalls.
// Depends on xfr_pkg for the result word type.
`default_nettype none

module xfr_out_buf
	import xfr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  result_t   push_word,
	output logic      space,
	output logic      valid,
	input  wire logic ready,
	output result_t   word
);

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign space = (count_q != 2'd2);
	assign valid = (count_q != 2'd0);
	assign pop   = valid && ready;
	assign word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/xor_frame_receiver.sv
// Top level of the XOR-checksum frame receiver: input byte register, parser, result buffer.
// Depends on xfr_pkg, xfr_parser and xfr_out_buf.
//
// Channel  Direction  Word contents
// s        in         tdata[7:0] rx_byte
// m        out        tuser[1:0] result_kind; tdata frame_id, frame_len, data_byte,
//                     byte_index, slot_index
//
// One byte is accepted per cycle while the result buffer has space.
// The byte is registered, parsed combinationally and its result written to a
// two-word output buffer, so a stalled output does not block input until both
// buffer words are full. Reset returns the parser to waiting for a header and
// the ring slot to zero.
`default_nettype none

module xor_frame_receiver
	import xfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [7:0] frame_id, [15:8] frame_len, [23:16] data_byte,
	                                    // [31:24] byte_index, [34:32] slot_index, [39:35] zero
	output logic [1:0]       m_tuser    // [1:0] result_kind
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       buf_space;
	logic       res_valid;
	result_t    res;
	result_t    out_word;

	assign step     = valid_s1 && buf_space;
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	xfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	xfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step && res_valid),
		.push_word (res),
		.space     (buf_space),
		.valid     (m_tvalid),
		.ready     (m_tready),
		.word      (out_word)
	);

	assign m_tuser = out_word.kind;
	assign m_tdata = {5'd0, out_word.slot_index, out_word.byte_index,
		out_word.data_byte, out_word.frame_len, out_word.frame_id};

endmodule

`default_nettype wire
